### rtl/core/mswd_pkg.sv
package mswd_pkg;

  // Number of switches polled through the block and the index width they need.
  localparam int NUM_SWITCHES = 8;
  localparam int SW_IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  // Field and counter widths.
  localparam int INDEX_W = 8;
  localparam int CNT_W = 16;

  // Debounce threshold after reset.
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 16'd20;

  // Per-switch debounce mode; the fourth code is never produced.
  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_BOUNCING = 2'd2
  } mode_t;

  // One poll request.
  typedef struct packed {
    logic [INDEX_W-1:0] switch_index;
    logic               pin_level;
  } req_t;

  // One reported result.
  typedef struct packed {
    logic is_pressed;
    logic index_error;
  } res_t;

endpackage

### rtl/core/mswd_in_reg.sv
module mswd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mswd_pkg::req_t in_req,
  input  logic          advance,
  output logic          s1_valid,
  output mswd_pkg::req_t s1_req
);

  // The register takes a new request whenever it is empty or drains this cycle.
  assign in_ready = !s1_valid || advance;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Request payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= in_req;
    end
  end

endmodule

### rtl/core/mswd_update.sv
module mswd_update (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [mswd_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         fire,
  input  mswd_pkg::req_t               req,
  output mswd_pkg::res_t               res
);

  mswd_pkg::mode_t            mode [mswd_pkg::NUM_SWITCHES];
  logic [mswd_pkg::CNT_W-1:0] high_cnt [mswd_pkg::NUM_SWITCHES];
  logic [mswd_pkg::CNT_W-1:0] low_cnt [mswd_pkg::NUM_SWITCHES];
  logic [mswd_pkg::CNT_W-1:0] threshold;

  logic [mswd_pkg::SW_IDX_W-1:0] idx;
  logic                          err;
  mswd_pkg::mode_t               cur_mode;
  logic [mswd_pkg::CNT_W-1:0]    high_inc;
  logic [mswd_pkg::CNT_W-1:0]    low_inc;
  mswd_pkg::mode_t               mode_next;
  logic [mswd_pkg::CNT_W-1:0]    high_cnt_next;
  logic [mswd_pkg::CNT_W-1:0]    low_cnt_next;
  logic                          rep;

  // Threshold register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= mswd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // Range check and lookup of the polled switch.
  assign err = req.switch_index >= mswd_pkg::INDEX_W'(mswd_pkg::NUM_SWITCHES);
  assign idx = req.switch_index[mswd_pkg::SW_IDX_W-1:0];
  assign cur_mode = mode[idx];
  assign high_inc = high_cnt[idx] + mswd_pkg::CNT_W'(1);
  assign low_inc = low_cnt[idx] + mswd_pkg::CNT_W'(1);

  // Next state of the polled switch and the level it reports.
  always_comb begin
    mode_next = cur_mode;
    high_cnt_next = high_cnt[idx];
    low_cnt_next = low_cnt[idx];
    rep = 1'b0;
    case (cur_mode)
      mswd_pkg::MODE_RELEASED: begin
        if (req.pin_level) begin
          mode_next = mswd_pkg::MODE_BOUNCING;
        end
        rep = 1'b0;
      end
      mswd_pkg::MODE_PRESSED: begin
        if (!req.pin_level) begin
          mode_next = mswd_pkg::MODE_BOUNCING;
        end
        rep = 1'b1;
      end
      default: begin
        // Bouncing: extend the run of the sampled level and clear the other.
        if (req.pin_level) begin
          high_cnt_next = high_inc;
          low_cnt_next = '0;
          if (high_inc > threshold) begin
            mode_next = mswd_pkg::MODE_PRESSED;
            rep = 1'b1;
          end else begin
            rep = 1'b0;
          end
        end else begin
          low_cnt_next = low_inc;
          high_cnt_next = '0;
          if (low_inc > threshold) begin
            mode_next = mswd_pkg::MODE_RELEASED;
            rep = 1'b0;
          end else begin
            rep = 1'b1;
          end
        end
      end
    endcase
  end

  // An out-of-range index reports released with the error flag.
  assign res.is_pressed = err ? 1'b0 : rep;
  assign res.index_error = err;

  // Per-switch state, updated when a valid in-range request is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mswd_pkg::NUM_SWITCHES; i++) begin
        mode[i] <= mswd_pkg::MODE_RELEASED;
        high_cnt[i] <= '0;
        low_cnt[i] <= '0;
      end
    end else if (fire && !err) begin
      mode[idx] <= mode_next;
      high_cnt[idx] <= high_cnt_next;
      low_cnt[idx] <= low_cnt_next;
    end
  end

endmodule

### rtl/core/mswd_out_reg.sv
module mswd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s1_valid,
  input  mswd_pkg::res_t res,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_ready,
  output mswd_pkg::res_t out_res
);

  // The result register loads when it is empty or its result is taken.
  assign advance = !out_valid || out_ready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_res <= res;
    end
  end

endmodule

### rtl/core/multi_switch_debouncer.sv
// Debouncer for a bank of switches polled one request at a time. Each request
// names a switch and its sampled pin level; the block answers every request
// with one result carrying the debounced level, or an error flag when the
// index is beyond the switch count. A request is taken every cycle while the
// pipeline is not stalled. It waits in the input register; as it advances, the
// per-switch state is read and written while the result register loads, so
// back-to-back requests to one switch see each other's updates. A stalled
// result holds the pipeline; the input is refused only while both registers
// are full. The threshold register is written via the always-ready config port;
// the user must do so only while no request is in flight; it is not enforced.
module multi_switch_debouncer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mswd_pkg::INDEX_W-1:0] switch_index,
  input  logic                       pin_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_pressed,
  output logic                       index_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mswd_pkg::CNT_W-1:0] debounce_threshold
);

  mswd_pkg::req_t in_req;
  mswd_pkg::req_t s1_req;
  mswd_pkg::res_t res;
  mswd_pkg::res_t out_res;
  logic           s1_valid;
  logic           advance;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  assign in_req.switch_index = switch_index;
  assign in_req.pin_level = pin_level;

  // Input register.
  mswd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  // Per-switch state and update logic.
  mswd_update u_update (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (debounce_threshold),
    .fire      (s1_valid && advance),
    .req       (s1_req),
    .res       (res)
  );

  // Result register.
  mswd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign is_pressed = out_res.is_pressed;
  assign index_error = out_res.index_error;

endmodule

### rtl/core/mswd_checker.sv
module mswd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_pressed,
  input logic index_error
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_pressed) && $stable(index_error))
    else $error("result changed while stalled");

  // The block only refuses requests while a result is held back.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A new result follows an accepted request, through the input and result registers.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // An index error always reports released.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> !is_pressed)
    else $error("index error reported as pressed");

endmodule

bind multi_switch_debouncer mswd_checker u_mswd_checker (.*);
